>>> hw/rtl/rmt_pkg.sv
// rmt_pkg: shared types and constants of the running mode tracker.
// Holds the table entry layout, the controller states and the field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

  // Field widths of the stream words
  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - COUNT_W - 1;

  // Hash fold width
  localparam int FOLD_W = 16;

  // Set epoch tag kept with every entry; tag zero means empty
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/rmt_hash.sv
// rmt_hash: maps a 32-bit key onto a home slot of the count table.
// Folds the key to 16 bits and scales it into 0..TABLE_ENTRIES-1.
// Depends on rmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmt_hash #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic [rmt_pkg::KEY_W-1:0]        key,
  output logic      [$clog2(TABLE_ENTRIES)-1:0] slot
);
  import rmt_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int PROD_W = FOLD_W + CNT_W;

  logic [FOLD_W-1:0] fold;
  logic [PROD_W-1:0] prod;

  // xor fold, then range reduction: (fold * entries) >> 16 is always below entries
  assign fold = key[KEY_W-1:FOLD_W] ^ key[FOLD_W-1:0] ^ {key[7:0], key[31:24]};
  assign prod = PROD_W'(fold) * PROD_W'(TABLE_ENTRIES);
  assign slot = prod[FOLD_W +: IDX_W];

endmodule

`default_nettype wire

>>> hw/rtl/rmt_table_mem.sv
// rmt_table_mem: single-port-write, single-port-read table of key/count entries.
// Read data is registered and holds until the next read.
// Depends on rmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmt_table_mem #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output rmt_pkg::entry_t               rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rmt_pkg::entry_t               wr_data
);
  import rmt_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/running_mode_tracker.sv
// running_mode_tracker: running mode of a stream of 32-bit values.
// Hashed key/count table in synchronous memory with linear probing.
// Depends on rmt_pkg, rmt_hash and rmt_table_mem.
//
// Usage:
//   in_*  : one word per value. in_tdata = value; in_tuser = first (starts a new set).
//   out_* : one word per input word: mode value, its count and the overflow flag.
//   An input word is taken at the edge where in_tvalid and in_tready are high; the
//   table read is issued on that edge, and the result passes from the registered read
//   data through the lookup check into the output register and is offered on out_*.
//   A word is read at its home slot, then once more for every occupied slot probed
//   past; a key absent from a full table probes all TABLE_ENTRIES slots. No new word
//   is taken until its lookup ends. Clearing a set bumps an 8-bit epoch tag kept in
//   every entry. After reset, and when a set starts with the epoch at its last value,
//   a clearing pass writes every entry with in_tready low.
//   The result sits in an output register; while out_tready is low the block still
//   takes the next word and waits in its final lookup step until the register frees.
//   Reset (rst_n low, synchronous) clears the best value, count, overflow flag and
//   the output valid, then runs the clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module running_mode_tracker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // value [31:0]
  input  wire logic [rmt_pkg::IN_DATA_W-1:0]  in_tdata,
  // first [0]
  input  wire logic                           in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // mode_value [31:0], mode_count [47:32], table_overflow [48], zero [55:49]
  output logic      [rmt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready
);
  import rmt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   value_r, value_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   probe_r, probe_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               pend_r, pend_nxt;
  logic [KEY_W-1:0]   best_value_r, best_value_nxt;
  logic [COUNT_W-1:0] best_count_r, best_count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_value_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  logic [IDX_W-1:0]   hash_idx;
  logic [IDX_W-1:0]   idx_inc;
  logic               mem_rd_en, mem_wr_en;
  logic [IDX_W-1:0]   mem_rd_addr, mem_wr_addr;
  entry_t             mem_rd_data, mem_wr_data;
  logic               slot_empty, key_match, out_free, out_load;
  logic [COUNT_W-1:0] cnt_new;

  rmt_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_hash (
    .key  (in_tdata[KEY_W-1:0]),
    .slot (hash_idx)
  );

  rmt_table_mem #(
    .DEPTH(TABLE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // probe step with wrap, entry decode and saturating count
  assign idx_inc    = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign slot_empty = (mem_rd_data.tag != epoch_r);
  assign key_match  = !slot_empty && (mem_rd_data.key == value_r);
  assign cnt_new    = slot_empty ? COUNT_W'(1) :
                      (mem_rd_data.count == COUNT_MAX) ? COUNT_MAX :
                      mem_rd_data.count + COUNT_W'(1);
  assign out_free   = !out_valid_r || out_tready;

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      epoch_r      <= EPOCH_EMPTY;
      pend_r       <= 1'b0;
      best_value_r <= '0;
      best_count_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      pend_r       <= pend_nxt;
      best_value_r <= best_value_nxt;
      best_count_r <= best_count_nxt;
      ovf_r        <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    probe_r <= probe_nxt;
    if (out_load) begin
      out_value_r <= best_value_nxt;
      out_count_r <= best_count_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  // next state, memory requests and result load
  always_comb begin
    state_nxt      = state_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    probe_nxt      = probe_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    pend_nxt       = pend_r;
    best_value_nxt = best_value_r;
    best_count_nxt = best_count_r;
    ovf_nxt        = ovf_r;
    in_tready      = 1'b0;
    out_load       = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = idx_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = idx_r;
    mem_wr_data    = '{tag: epoch_r, key: value_r, count: cnt_new};
    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr_r;
        mem_wr_data = '{tag: EPOCH_EMPTY, key: '0, count: '0};
        if (clr_addr_r == LAST_IDX) begin
          clr_addr_nxt = '0;
          epoch_nxt    = EPOCH_FIRST;
          pend_nxt     = 1'b0;
          state_nxt    = pend_r ? S_LOOKUP : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          value_nxt = in_tdata[KEY_W-1:0];
          idx_nxt   = hash_idx;
          probe_nxt = '0;
          if (in_tuser) begin
            best_value_nxt = '0;
            best_count_nxt = '0;
            ovf_nxt        = 1'b0;
          end
          if (in_tuser && (epoch_r == EPOCH_LAST)) begin
            // tags would wrap: sweep the table first
            pend_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            if (in_tuser) begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
            mem_rd_en   = 1'b1;
            mem_rd_addr = hash_idx;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_LOOKUP: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_r;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (slot_empty || key_match) begin
          // insert or bump, then offer the result
          if (out_free) begin
            mem_wr_en = 1'b1;
            if (cnt_new > best_count_r) begin
              best_count_nxt = cnt_new;
              best_value_nxt = value_r;
            end
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (probe_r == LAST_IDX) begin
          // every slot held another key: table full
          if (out_free) begin
            ovf_nxt   = 1'b1;
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt     = idx_inc;
          probe_nxt   = probe_r + IDX_W'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_ovf_r, out_count_r, out_value_r};

  // the table never sees a read and a write in the same cycle
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en))
    else $error("table read and write in the same cycle");

  // a result is never loaded over one still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // an accepted word goes straight to lookup check or a clearing pass
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK || state_r == S_CLEAR))
    else $error("unexpected state after accept");

  // the best count only falls when a new set starts
  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (best_count_r < $past(best_count_r)) |-> $past(in_tvalid && in_tready && in_tuser))
    else $error("best count fell within a set");

  // a count written back during lookup is never zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && state_r == S_CHECK) |-> (mem_wr_data.count != '0))
    else $error("zero count written to table");

endmodule

`default_nettype wire

>>> tb/tb_running_mode_tracker.sv
// tb_running_mode_tracker: self-checking bench for the running mode tracker.
// A driver and a monitor drive and check the streams, with a predictor of the mode per word.
// Depends on rmt_pkg and running_mode_tracker.
`timescale 1ns / 1ps

module tb_running_mode_tracker;

  import rmt_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [KEY_W-1:0] value;
    logic             first;
    int               gap;
  } in_word_t;

  typedef struct {
    logic [KEY_W-1:0]   mode_value;
    logic [COUNT_W-1:0] mode_count;
    logic               overflow;
  } mode_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  running_mode_tracker #(.TABLE_ENTRIES(TBL_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus and expected results
  in_word_t   pending[$];
  mode_word_t mode_expect[$];

  // Predictor state: per-key tally of the current set
  int unsigned        tally[logic [KEY_W-1:0]];
  logic [KEY_W-1:0]   best_value = '0;
  logic [COUNT_W-1:0] best_count = '0;
  logic               overflow_seen = 1'b0;

  int errors = 0;
  int results_seen = 0;
  int hold_at = 0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;

  // Count one value into the running set and queue the mode it leaves
  function automatic void predict_mode(logic [KEY_W-1:0] v, logic first);
    mode_word_t m;
    if (first) begin
      tally.delete();
      best_value = '0;
      best_count = '0;
      overflow_seen = 1'b0;
    end
    if (tally.exists(v) || tally.num() < TBL_DEPTH) begin
      if (!tally.exists(v)) tally[v] = 0;
      if (tally[v] < COUNT_MAX) tally[v] = tally[v] + 1;
      if (tally[v] > best_count) begin
        best_count = COUNT_W'(tally[v]);
        best_value = v;
      end
    end else begin
      overflow_seen = 1'b1;
    end
    m.mode_value = best_value;
    m.mode_count = best_count;
    m.overflow   = overflow_seen;
    mode_expect.push_back(m);
  endfunction

  function automatic void push_word(logic [KEY_W-1:0] v, logic first, int gap);
    in_word_t w;
    w.value = v;
    w.first = first;
    w.gap   = gap;
    pending.push_back(w);
  endfunction

  // Pool values lean on the extremes now and then
  function automatic logic [KEY_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return KEY_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Handshake tracking, prediction and checking at the rising edge
  always @(posedge clk) begin
    mode_word_t m;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) predict_mode(in_tdata[KEY_W-1:0], in_tuser);
    if (rst_n && out_tvalid && out_tready) begin
      if (mode_expect.size() == 0) begin
        if (errors < 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, out_tdata);
        errors++;
      end else begin
        m = mode_expect.pop_front();
        if (out_tdata[31:0] !== m.mode_value || out_tdata[47:32] !== m.mode_count ||
            out_tdata[48] !== m.overflow) begin
          if (errors < 10)
            $display("mismatch on result %0d: expected %h/%0d/%b, got %h/%0d/%b",
                     results_seen, m.mode_value, m.mode_count, m.overflow,
                     out_tdata[31:0], out_tdata[47:32], out_tdata[48]);
          errors++;
        end
      end
      results_seen++;
    end
  end

  // Driver: one word per slot, with the drawn gap after each
  int gap_left = 0;
  always @(negedge clk) begin
    in_word_t w;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        w = pending.pop_front();
        in_tdata  <= w.value;
        in_tuser  <= w.first;
        in_tvalid <= 1'b1;
        gap_left  = w.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls per word, busy and quiet runs, one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  int  rx_run_left = 0;
  bit  rx_busy = 1'b0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        if (rx_run_left == 0) begin
          rx_busy = $urandom_range(0, 1);
          rx_run_left = 40;
        end
        rx_run_left--;
        if (!rx_busy)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 12);
        if (!hold_done && results_seen >= hold_at) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        if (out_tvalid) stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n_words;
    int kind;
    int len;
    int pool_n;
    int set_gap;
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] base;

    // Directed: no first flag after reset, extremes, ties, restarts
    push_word(32'h0000_0005, 1'b0, 0);
    push_word(32'h8000_0000, 1'b0, 3);
    push_word(32'h8000_0000, 1'b0, 0);
    push_word(32'h0000_0005, 1'b0, 0);  // tie keeps the earlier leader
    push_word(32'h7fff_ffff, 1'b1, 5);
    push_word(32'hffff_ffff, 1'b0, 0);
    push_word(32'h0000_0000, 1'b0, 0);
    push_word(32'h0000_0000, 1'b0, 12);
    push_word(32'hffff_ffff, 1'b0, 0);
    push_word(32'hffff_ffff, 1'b0, 0);
    push_word(32'h0001_0000, 1'b1, 0);
    push_word(32'h0000_0001, 1'b0, 1);
    push_word(32'h0001_0001, 1'b0, 0);
    push_word(32'h0000_0001, 1'b0, 0);
    push_word(32'haaaa_aaaa, 1'b1, 0);
    push_word(32'h5555_5555, 1'b0, 2);
    push_word(32'h5555_5555, 1'b1, 0);  // restart on a repeated value
    push_word(32'h5555_5555, 1'b0, 0);

    // long receiver hold-off part way into the random sets
    hold_at = pending.size() + 100;

    // Random sets
    n_words = 0;
    while (n_words < 500) begin
      kind = $urandom_range(0, 9);
      pool.delete();
      if (kind <= 5) begin
        pool_n = $urandom_range(1, 8);
        len = $urandom_range(1, 40);
      end else if (kind <= 7) begin
        pool_n = $urandom_range(TBL_DEPTH - 4, TBL_DEPTH + 26);
        len = pool_n + $urandom_range(0, 50);
      end else if (kind == 8) begin
        pool_n = 0;
        len = $urandom_range(1, 20);
      end else begin
        pool_n = $urandom_range(4, 16);
        len = $urandom_range(20, 60);
      end
      base = $urandom;
      for (int k = 0; k < pool_n; k++) begin
        if (kind == 9) pool.push_back(base ^ (KEY_W'(k) << (($urandom_range(0, 1)) ? 16 : 20)));
        else if (kind <= 5) pool.push_back(pick_value());
        else pool.push_back(base + KEY_W'(k) * 32'h0001_0001);
      end
      set_gap = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        logic [KEY_W-1:0] v;
        if (pool_n == 0) v = $urandom;
        else if ((kind == 6 || kind == 7) && i < pool_n) v = pool[i];
        else v = pool[$urandom_range(0, pool_n - 1)];
        push_word(v, (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0),
                  (set_gap == 0) ? 0 : $urandom_range(0, 12));
      end
      n_words += len;
    end

    // Synchronous reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (mode_expect.size() != 0) @(posedge clk);
    repeat (2 * TBL_DEPTH + 20) @(posedge clk);

    if (errors == 0 && mode_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
